@@ hdl/dfm_pkg.sv @@
`default_nettype none

package dfm_pkg;

  localparam int unsigned ValueW = 16;
  localparam int unsigned CountW = 3;
  localparam int unsigned CharW  = 6;
  localparam int unsigned DigitW = 4;
  localparam int unsigned LimitW = 17;
  localparam int unsigned BitCntW = 4;

  localparam logic [CharW-1:0] AsciiZero  = 6'd48;
  localparam logic [CharW-1:0] AsciiSpace = 6'd32;

  // Largest value that fits a field of one to five digits.
  localparam logic [LimitW-1:0] FieldLimit [5] = '{
    17'd9, 17'd99, 17'd999, 17'd9999, 17'd99999
  };

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StEmit
  } dfm_state_e;

  // Control shared by every digit cell of the converter row.
  typedef struct packed {
    logic clear;
    logic shift;
  } dfm_cell_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/dfm_in_if.sv @@
`default_nettype none

interface dfm_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] value;
  logic [2:0]  digit_count;

  modport source (output valid, output value, output digit_count, input ready);
  modport sink   (input valid, input value, input digit_count, output ready);
endinterface

`default_nettype wire

@@ hdl/dfm_out_if.sv @@
`default_nettype none

interface dfm_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

@@ hdl/dfm_bcd_cell.sv @@
`default_nettype none

module dfm_bcd_cell (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire dfm_pkg::dfm_cell_ctrl_t   ctrl_i,
  input  wire logic                      bit_i,
  output logic                           bit_o,
  output logic [dfm_pkg::DigitW-1:0]     digit_o
);

  logic [dfm_pkg::DigitW-1:0] digit_q, digit_d, adj;

  // Add three before the shift so the digit carries out at ten.
  always_comb begin
    adj = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
    bit_o = adj[3];
    digit_d = digit_q;
    if (ctrl_i.clear) begin
      digit_d = '0;
    end else if (ctrl_i.shift) begin
      digit_d = {adj[2:0], bit_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else begin
      digit_q <= digit_d;
    end
  end

  assign digit_o = digit_q;

endmodule

`default_nettype wire

@@ hdl/decimal_field_formatter.sv @@
`default_nettype none

// Channel  Direction  Payload                          Meaning
// in_i     sink       value[15:0], digit_count[2:0]    number and field width
// out_o    source     character[5:0], last             one ASCII character per request
//
// An input request is taken only while the block is idle. It then shifts all
// sixteen bits of the saturated value, one bit a cycle, through the row of
// BCD digit cells, and then offers one character per cycle while out_o.ready
// is high. A zero width is taken and yields no characters. The output payload
// holds steady while out_o.ready is low. Reset (rst_ni, asynchronous, active
// low) returns to idle.

module decimal_field_formatter #(
  parameter int unsigned MAX_DIGITS = 5
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dfm_in_if.sink    in_i,
  dfm_out_if.source out_o
);

  localparam int unsigned IdxW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  dfm_pkg::dfm_state_e state_q, state_d;

  logic [dfm_pkg::ValueW-1:0]  value_q, value_d;
  logic [dfm_pkg::BitCntW-1:0] bit_cnt_q, bit_cnt_d;
  logic [IdxW-1:0]             idx_q, idx_d;
  logic                        shown_q, shown_d;

  logic                        in_take;
  logic                        out_take;
  logic [dfm_pkg::CountW-1:0]  width_eff;
  logic [dfm_pkg::LimitW-1:0]  limit;
  logic [dfm_pkg::ValueW-1:0]  value_sat;

  dfm_pkg::dfm_cell_ctrl_t     cell_ctrl;
  logic [dfm_pkg::DigitW-1:0]  digits [MAX_DIGITS];
  logic                        carry  [MAX_DIGITS];

  logic [dfm_pkg::DigitW-1:0]  cur_digit;
  logic                        show_digit;

  assign in_take  = in_i.valid && in_i.ready;
  assign out_take = out_o.valid && out_o.ready;

  // Widths above the number of cells fall back to the full row.
  assign width_eff = (in_i.digit_count > dfm_pkg::CountW'(MAX_DIGITS))
                   ? dfm_pkg::CountW'(MAX_DIGITS) : in_i.digit_count;

  // Saturate to the largest number that fits the field. A zero width is
  // caught by the state machine, so its table entry is never used.
  assign limit     = dfm_pkg::FieldLimit[width_eff - 3'd1];
  assign value_sat = ({1'b0, in_i.value} > limit) ? limit[dfm_pkg::ValueW-1:0]
                                                  : in_i.value;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      dfm_pkg::StIdle: begin
        if (in_take && (width_eff != '0)) begin
          state_d = dfm_pkg::StConv;
        end
      end
      dfm_pkg::StConv: begin
        if (bit_cnt_q == '0) begin
          state_d = dfm_pkg::StEmit;
        end
      end
      dfm_pkg::StEmit: begin
        if (out_take && (idx_q == '0)) begin
          state_d = dfm_pkg::StIdle;
        end
      end
      default: begin
        state_d = dfm_pkg::StIdle;
      end
    endcase
  end

  // Outputs and datapath control.
  always_comb begin
    in_i.ready      = 1'b0;
    out_o.valid     = 1'b0;
    cell_ctrl.clear = 1'b0;
    cell_ctrl.shift = 1'b0;
    value_d   = value_q;
    bit_cnt_d = bit_cnt_q;
    idx_d     = idx_q;
    shown_d   = shown_q;
    case (state_q)
      dfm_pkg::StIdle: begin
        in_i.ready = 1'b1;
        if (in_take) begin
          cell_ctrl.clear = 1'b1;
          value_d   = value_sat;
          bit_cnt_d = dfm_pkg::BitCntW'(dfm_pkg::ValueW - 1);
          idx_d     = IdxW'(width_eff - 3'd1);
          shown_d   = 1'b0;
        end
      end
      dfm_pkg::StConv: begin
        cell_ctrl.shift = 1'b1;
        value_d   = {value_q[dfm_pkg::ValueW-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q - 4'd1;
      end
      dfm_pkg::StEmit: begin
        out_o.valid = 1'b1;
        if (out_take) begin
          shown_d = show_digit;
          if (idx_q != '0) begin
            idx_d = idx_q - 1'b1;
          end
        end
      end
      default: begin
        in_i.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dfm_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q   <= value_d;
    bit_cnt_q <= bit_cnt_d;
    idx_q     <= idx_d;
    shown_q   <= shown_d;
  end

  // Row of BCD cells: the value enters cell zero MSB first, and each cell
  // passes its carry to the next more significant digit.
  assign carry[0] = value_q[dfm_pkg::ValueW-1];

  for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
    if (i < MAX_DIGITS - 1) begin : g_mid
      dfm_bcd_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (cell_ctrl),
        .bit_i  (carry[i]),
        .bit_o  (carry[i+1]),
        .digit_o(digits[i])
      );
    end else begin : g_top
      dfm_bcd_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (cell_ctrl),
        .bit_i  (carry[i]),
        .bit_o  (),
        .digit_o(digits[i])
      );
    end
  end

  // Leading zeros print as spaces; the units digit always prints.
  assign cur_digit  = digits[idx_q];
  assign show_digit = shown_q || (cur_digit != '0) || (idx_q == '0);

  assign out_o.character = show_digit
                         ? dfm_pkg::AsciiZero + {2'b00, cur_digit}
                         : dfm_pkg::AsciiSpace;
  assign out_o.last      = (idx_q == '0);

endmodule

`default_nettype wire

@@ bench/decimal_field_formatter_tb.sv @@
module decimal_field_formatter_tb;

  localparam int unsigned MaxDigits = 5;

  // ItemCycles is the time one item at the widest field takes when nobody stalls.
  localparam int unsigned ItemCycles = 17 + MaxDigits;

  // The slowest correct item has the longest gap at the sender, the conversion,
  // and five characters each held up by the longest stall at the receiver.
  // The limit lies far above the slowest correct run of all items.
  localparam int unsigned CycleLimit = 400_000;

  localparam int unsigned RandomItems = 250;
  localparam int unsigned MaxGap      = 19;

  // One character of a formatted field as the output channel carries it.
  typedef struct packed {
    logic [dfm_pkg::CharW-1:0] code;
    logic                      last;
  } field_char_t;

  // A row of the directed table. Where typed is set, text holds the field as
  // it must appear, and an empty text means the request yields nothing.
  // Other rows are checked against the predictor.
  typedef struct {
    logic [dfm_pkg::ValueW-1:0] value;
    logic [dfm_pkg::CountW-1:0] count;
    bit                         typed;
    string                      text;
  } field_case_t;

  localparam int unsigned NumCases = 22;

  field_case_t field_cases [NumCases] = '{
    // Zero shows as a single digit, right-aligned behind blanks.
    '{16'd0,     3'd1, 1'b1, "0"},
    '{16'd0,     3'd5, 1'b1, "    0"},
    // The largest value fits five digits and is shown as it is.
    '{16'd65535, 3'd5, 1'b1, "65535"},
    // The largest value clamps to the biggest number of each narrower width.
    '{16'd65535, 3'd1, 1'b1, "9"},
    '{16'd65535, 3'd2, 1'b1, "99"},
    '{16'd65535, 3'd3, 1'b1, "999"},
    '{16'd65535, 3'd4, 1'b1, "9999"},
    // A width above the maximum behaves as the maximum.
    '{16'd65535, 3'd7, 1'b1, "65535"},
    '{16'd12,    3'd6, 1'b1, "   12"},
    // A width of zero is taken but yields no characters at all.
    '{16'd1234,  3'd0, 1'b1, ""},
    '{16'd0,     3'd0, 1'b1, ""},
    // Just at and just above the one-digit limit.
    '{16'd9,     3'd1, 1'b1, "9"},
    '{16'd10,    3'd1, 1'b1, "9"},
    // Boundaries around powers of ten, and zeros inside a shown number.
    '{16'd100,   3'd2, 1'b0, ""},
    '{16'd1000,  3'd3, 1'b0, ""},
    '{16'd10000, 3'd4, 1'b0, ""},
    '{16'd10000, 3'd5, 1'b0, ""},
    '{16'd7,     3'd3, 1'b0, ""},
    '{16'd105,   3'd4, 1'b0, ""},
    '{16'd40960, 3'd5, 1'b0, ""},
    '{16'd99,    3'd5, 1'b0, ""},
    '{16'd1,     3'd2, 1'b0, ""}
  };

  logic clk_i;
  logic rst_ni;

  dfm_in_if  in_bus ();
  dfm_out_if out_bus ();

  decimal_field_formatter #(
    .MAX_DIGITS(MaxDigits)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  // Characters that accepted requests still owe, oldest first.
  field_char_t pending_chars [$];

  int unsigned mismatches;
  int unsigned cycles;

  // While a burst flag is set, that side runs at full speed.
  bit send_burst;
  bit recv_burst;

  initial begin
    clk_i = 1'b0;
  end

  always #1 clk_i = ~clk_i;

  // The cycle counter guards against a hung block.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d characters outstanding", cycles,
               pending_chars.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  // Works out the characters of one field and queues them. The value is
  // clamped to the largest number that fits the width, leading zeros become
  // blanks, and the units digit is always shown.
  function automatic void predict_field(input logic [dfm_pkg::ValueW-1:0] value,
                                        input logic [dfm_pkg::CountW-1:0] count);
    int unsigned place_of [5];
    int unsigned width;
    int unsigned num;
    int unsigned limit;
    int unsigned digit;
    bit          shown;
    field_char_t fc;

    place_of = '{1, 10, 100, 1000, 10000};
    width    = (count > MaxDigits) ? MaxDigits : count;
    if (width == 0) begin
      return;
    end
    limit = place_of[width-1] * 10 - 1;
    num   = (value > limit) ? limit : value;
    shown = 1'b0;
    for (int k = width; k > 0; k--) begin
      digit = num / place_of[k-1];
      if (k == 1) begin
        shown = 1'b1;
      end
      if (digit != 0 || shown) begin
        fc.code = dfm_pkg::AsciiZero + dfm_pkg::CharW'(digit);
        shown   = 1'b1;
      end else begin
        fc.code = dfm_pkg::AsciiSpace;
      end
      fc.last = (k == 1);
      num     = num % place_of[k-1];
      pending_chars.push_back(fc);
    end
  endfunction

  // Queues the characters of a field that is typed in as text.
  function automatic void queue_text(input string text);
    field_char_t fc;

    for (int i = 0; i < text.len(); i++) begin
      fc.code = dfm_pkg::CharW'(text[i]);
      fc.last = (i == text.len() - 1);
      pending_chars.push_back(fc);
    end
  endfunction

  function automatic int unsigned draw_gap(input bit burst);
    return burst ? 0 : $urandom_range(0, MaxGap);
  endfunction

  // Offers one input request and waits until the block takes it. Valid is
  // left high afterwards, so that a following request without a gap keeps
  // it high instead of lowering and raising it in the same step.
  task automatic send_request(input logic [dfm_pkg::ValueW-1:0] value,
                              input logic [dfm_pkg::CountW-1:0] count,
                              input bit typed, input string text);
    int unsigned gap;

    gap = draw_gap(send_burst);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid       <= 1'b1;
    in_bus.value       <= value;
    in_bus.digit_count <= count;
    do begin
      @(posedge clk_i);
    end while (!in_bus.ready);
    if (typed) begin
      queue_text(text);
    end else begin
      predict_field(value, count);
    end
  endtask

  // The sender holds off until every owed character has come out. It always
  // drops valid first, even when nothing is owed.
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_chars.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Random values lean toward small numbers and the edges of each width,
  // where saturation and blanking change.
  function automatic logic [dfm_pkg::ValueW-1:0] random_value();
    int unsigned place_of [5];
    int          near;

    place_of = '{1, 10, 100, 1000, 10000};
    case ($urandom_range(0, 3))
      0: return dfm_pkg::ValueW'($urandom);
      1: return dfm_pkg::ValueW'($urandom_range(0, 120));
      2: begin
        near = int'(place_of[$urandom_range(0, 4)]) + $urandom_range(0, 4) - 2;
        return (near < 0) ? '0 : dfm_pkg::ValueW'(near);
      end
      default: return dfm_pkg::ValueW'($urandom_range(0, 65535));
    endcase
  endfunction

  // Widths are mostly legal, with zero and oversize widths mixed in.
  function automatic logic [dfm_pkg::CountW-1:0] random_count();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return dfm_pkg::CountW'($urandom_range(6, 7));
      default: return dfm_pkg::CountW'($urandom_range(1, MaxDigits));
    endcase
  endfunction

  // Receiver: stalls for a random time before each character, then takes
  // the next output request and checks it against the oldest expectation.
  initial begin
    int unsigned stall;
    field_char_t want;

    out_bus.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 29) == 0) begin
        recv_burst = !recv_burst;
      end
      stall = draw_gap(recv_burst);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do begin
        @(posedge clk_i);
      end while (!(out_bus.valid && rst_ni));
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected character %0d last %0b",
                                  out_bus.character, out_bus.last));
      end else begin
        want = pending_chars.pop_front();
        if (out_bus.character !== want.code) begin
          report_mismatch($sformatf("character %0d, wanted %0d",
                                    out_bus.character, want.code));
        end
        if (out_bus.last !== want.last) begin
          report_mismatch($sformatf("last %0b, wanted %0b", out_bus.last,
                                    want.last));
        end
      end
    end
  end

  // Main sequence: reset, the directed table, the random part, the drain.
  initial begin
    mismatches         = 0;
    cycles             = 0;
    send_burst         = 1'b0;
    recv_burst         = 1'b0;
    rst_ni             <= 1'b0;
    in_bus.valid       <= 1'b0;
    in_bus.value       <= '0;
    in_bus.digit_count <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (field_cases[i]) begin
      send_request(field_cases[i].value, field_cases[i].count,
                   field_cases[i].typed, field_cases[i].text);
    end

    // Let the block run dry once before the random part begins.
    wait_drained();

    for (int n = 0; n < RandomItems; n++) begin
      if ($urandom_range(0, 29) == 0) begin
        send_burst = !send_burst;
      end
      if (n == RandomItems / 2) begin
        wait_drained();
      end
      send_request(random_value(), random_count(), 1'b0, "");
    end

    // Wait for every owed character, then watch a little longer for any
    // stray output request.
    wait_drained();
    repeat (3 * ItemCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/dfm_pkg.sv
hdl/dfm_in_if.sv
hdl/dfm_out_if.sv
hdl/dfm_bcd_cell.sv
hdl/decimal_field_formatter.sv
bench/decimal_field_formatter_tb.sv
